// ===== design/md5_pkg.sv =====
// ----------------------------------------------------------------------------
// MD5 package
// Step constants, rotate amounts and initial chaining values.
// ----------------------------------------------------------------------------
package md5_pkg;

  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hefcdab89;
  localparam logic [31:0] IV2 = 32'h98badcfe;
  localparam logic [31:0] IV3 = 32'h10325476;
  localparam logic [7:0]  PAD_LEAD = 8'h80;

  // one input byte
  typedef struct packed {
    logic [7:0] data_byte;
  } in_data_t;

  // step constant by step index
  function automatic logic [31:0] step_const(input logic [5:0] k);
    logic [31:0] r;
    case (k)
      6'd0: r = 32'd3614090360;  6'd1: r = 32'd3905402710;
      6'd2: r = 32'd606105819;   6'd3: r = 32'd3250441966;
      6'd4: r = 32'd4118548399;  6'd5: r = 32'd1200080426;
      6'd6: r = 32'd2821735955;  6'd7: r = 32'd4249261313;
      6'd8: r = 32'd1770035416;  6'd9: r = 32'd2336552879;
      6'd10: r = 32'd4294925233; 6'd11: r = 32'd2304563134;
      6'd12: r = 32'd1804603682; 6'd13: r = 32'd4254626195;
      6'd14: r = 32'd2792965006; 6'd15: r = 32'd1236535329;
      6'd16: r = 32'd4129170786; 6'd17: r = 32'd3225465664;
      6'd18: r = 32'd643717713;  6'd19: r = 32'd3921069994;
      6'd20: r = 32'd3593408605; 6'd21: r = 32'd38016083;
      6'd22: r = 32'd3634488961; 6'd23: r = 32'd3889429448;
      6'd24: r = 32'd568446438;  6'd25: r = 32'd3275163606;
      6'd26: r = 32'd4107603335; 6'd27: r = 32'd1163531501;
      6'd28: r = 32'd2850285829; 6'd29: r = 32'd4243563512;
      6'd30: r = 32'd1735328473; 6'd31: r = 32'd2368359562;
      6'd32: r = 32'd4294588738; 6'd33: r = 32'd2272392833;
      6'd34: r = 32'd1839030562; 6'd35: r = 32'd4259657740;
      6'd36: r = 32'd2763975236; 6'd37: r = 32'd1272893353;
      6'd38: r = 32'd4139469664; 6'd39: r = 32'd3200236656;
      6'd40: r = 32'd681279174;  6'd41: r = 32'd3936430074;
      6'd42: r = 32'd3572445317; 6'd43: r = 32'd76029189;
      6'd44: r = 32'd3654602809; 6'd45: r = 32'd3873151461;
      6'd46: r = 32'd530742520;  6'd47: r = 32'd3299628645;
      6'd48: r = 32'd4096336452; 6'd49: r = 32'd1126891415;
      6'd50: r = 32'd2878612391; 6'd51: r = 32'd4237533241;
      6'd52: r = 32'd1700485571; 6'd53: r = 32'd2399980690;
      6'd54: r = 32'd4293915773; 6'd55: r = 32'd2240044497;
      6'd56: r = 32'd1873313359; 6'd57: r = 32'd4264355552;
      6'd58: r = 32'd2734768916; 6'd59: r = 32'd1309151649;
      6'd60: r = 32'd4149444226; 6'd61: r = 32'd3174756917;
      6'd62: r = 32'd718787259;  6'd63: r = 32'd3951481745;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

  // rotate amount by round and step within the group of four
  function automatic logic [4:0] step_rot(input logic [3:0] i);
    logic [4:0] r;
    case (i)
      4'd0: r = 5'd7;   4'd1: r = 5'd12;  4'd2: r = 5'd17;  4'd3: r = 5'd22;
      4'd4: r = 5'd5;   4'd5: r = 5'd9;   4'd6: r = 5'd14;  4'd7: r = 5'd20;
      4'd8: r = 5'd4;   4'd9: r = 5'd11;  4'd10: r = 5'd16; 4'd11: r = 5'd23;
      4'd12: r = 5'd6;  4'd13: r = 5'd10; 4'd14: r = 5'd15; 4'd15: r = 5'd21;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  // message word index used by step k
  function automatic logic [3:0] msg_index(input logic [5:0] k);
    logic [3:0] g;
    case (k[5:4])
      2'd0: g = k[3:0];
      2'd1: g = 4'((k * 5) + 1);
      2'd2: g = 4'((k * 3) + 5);
      default: g = 4'(k * 7);
    endcase
    return g;
  endfunction

endpackage

// ===== design/md5_message_digest.sv =====
// ----------------------------------------------------------------------------
// MD5 message digest
// Byte stream in, 128-bit digest out at the end of each message.
// ----------------------------------------------------------------------------
// A byte word is taken and merged into the 16-word block memory.
// A full block stalls input while it is compressed: one step of the shared round unit
// per cycle (the first word is read ahead), then the chain update.
// End of message pads word by word and compresses once or twice; the digest is
// registered and held until taken.
// Reset is synchronous and restores the initial chaining values at once.
module md5_message_digest (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tuser,   // has_byte
  input  logic        s_tlast,   // end_of_message
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [127:0] m_tdata   // digest_word0..3, word0 lowest
);
  import md5_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_PAD, S_LEN, S_RUN, S_FIN, S_OUT
  } state_t;

  state_t      state;
  logic [31:0] block_mem [16];
  logic [31:0] rd_data;
  logic [3:0]  rd_addr;
  logic        wr_en;
  logic [3:0]  wr_addr;
  logic [31:0] wr_data;

  logic [31:0] h0, h1, h2, h3;
  logic [31:0] a, b, c, d;
  logic [63:0] bit_count;
  logic [63:0] bit_count_inc;
  logic [63:0] len;
  logic [31:0] cur_word;
  logic        finishing;
  logic        second;
  logic [3:0]  pad_idx;
  logic [6:0]  step;
  logic [31:0] b_new;
  logic [5:0]  pos;

  assign pos = bit_count[8:3];
  assign bit_count_inc = bit_count + 64'd8;
  assign s_tready = (state == S_IDLE) && !m_tvalid;

  // block memory, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      block_mem[wr_addr] <= wr_data;
    end
    rd_data <= block_mem[rd_addr];
  end

  // read one step ahead
  always_comb begin
    if (state == S_RUN && step < 7'd63) begin
      rd_addr = msg_index(6'(step + 7'd1));
    end else begin
      rd_addr = msg_index(6'd0);
    end
  end

  md5_round u_round (
    .k(step[5:0]), .a(a), .b(b), .c(c), .d(d), .w(rd_data), .b_new(b_new)
  );

  // memory write side
  always_comb begin
    wr_en = 1'b0;
    wr_addr = pos[5:2];
    wr_data = cur_word;
    if (state == S_IDLE && s_tvalid && s_tready && s_tuser) begin
      wr_en = 1'b1;
      case (pos[1:0])
        2'd0: wr_data = {24'd0, s_tdata};
        2'd1: wr_data = {16'd0, s_tdata, cur_word[7:0]};
        2'd2: wr_data = {8'd0, s_tdata, cur_word[15:0]};
        default: wr_data = {s_tdata, cur_word[23:0]};
      endcase
    end else if (state == S_PAD) begin
      wr_en = 1'b1;
      wr_addr = pad_idx;
      wr_data = 32'd0;
      if (pad_idx == len[8:5]) begin
        case (len[4:3])
          2'd0: wr_data = {24'd0, PAD_LEAD};
          2'd1: wr_data = {16'd0, PAD_LEAD, cur_word[7:0]};
          2'd2: wr_data = {8'd0, PAD_LEAD, cur_word[15:0]};
          default: wr_data = {PAD_LEAD, cur_word[23:0]};
        endcase
      end
    end else if (state == S_LEN) begin
      wr_en = 1'b1;
      wr_addr = pad_idx;
      wr_data = (pad_idx == 4'd14) ? len[31:0] : len[63:32];
      if (second && pad_idx < 4'd14) begin
        wr_data = 32'd0;
      end
    end
  end

  // control sequence
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      m_tvalid <= 1'b0;
      h0 <= IV0; h1 <= IV1; h2 <= IV2; h3 <= IV3;
      bit_count <= 64'd0;
      finishing <= 1'b0;
      second <= 1'b0;
      step <= 7'd0;
      pad_idx <= 4'd0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid && s_tready) begin
            if (s_tuser) begin
              cur_word <= wr_data;
              bit_count <= bit_count_inc;
            end
            if (s_tuser && pos == 6'd63) begin
              finishing <= s_tlast;
              second <= 1'b0;
              len <= bit_count_inc;
              pad_idx <= 4'd0;
              step <= 7'd0;
              a <= h0; b <= h1; c <= h2; d <= h3;
              state <= S_RUN;
            end else if (s_tlast) begin
              len <= s_tuser ? bit_count_inc : bit_count;
              finishing <= 1'b0;
              second <= 1'b0;
              pad_idx <= s_tuser ? bit_count_inc[8:5] : bit_count[8:5];
              state <= S_PAD;
            end
          end
        end
        // lead byte and zeros after the last message byte
        S_PAD: begin
          if (pad_idx == 4'd15) begin
            if (len[8:3] >= 6'd56) begin
              a <= h0; b <= h1; c <= h2; d <= h3;
              step <= 7'd0;
              second <= 1'b1;
              state <= S_RUN;
            end else begin
              pad_idx <= 4'd14;
              state <= S_LEN;
            end
          end else begin
            pad_idx <= pad_idx + 4'd1;
          end
        end
        // length words, after zero words 0..13 when a second block is needed
        S_LEN: begin
          if (pad_idx == 4'd15) begin
            a <= h0; b <= h1; c <= h2; d <= h3;
            step <= 7'd0;
            second <= 1'b0;
            finishing <= 1'b1;
            state <= S_RUN;
          end else begin
            pad_idx <= pad_idx + 4'd1;
          end
        end
        S_RUN: begin
          a <= d; d <= c; c <= b; b <= b_new;
          if (step == 7'd63) begin
            state <= S_FIN;
          end
          step <= step + 7'd1;
        end
        S_FIN: begin
          h0 <= h0 + a; h1 <= h1 + b; h2 <= h2 + c; h3 <= h3 + d;
          if (second) begin
            pad_idx <= 4'd0;
            state <= S_LEN;
          end else if (finishing) begin
            // a full block that ended the message still needs the padding block
            if (pad_idx == 4'd15) begin
              state <= S_OUT;
            end else begin
              pad_idx <= 4'd0;
              finishing <= 1'b0;
              state <= S_PAD;
            end
          end else begin
            state <= S_IDLE;
          end
        end
        S_OUT: begin
          m_tdata <= {h3, h2, h1, h0};
          m_tvalid <= 1'b1;
          h0 <= IV0; h1 <= IV1; h2 <= IV2; h3 <= IV3;
          bit_count <= 64'd0;
          finishing <= 1'b0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // a result never appears while a block is being compressed
  assert property (@(posedge clk) disable iff (rst)
    state == S_RUN |-> !$rose(m_tvalid)) else $error("digest during rounds");
  // input stalls while compressing
  assert property (@(posedge clk) disable iff (rst)
    state == S_RUN |-> !s_tready) else $error("ready during rounds");
  // the step counter runs the full block
  assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN && step != 7'd63) |=> state == S_RUN) else $error("short run");

endmodule

// ===== design/md5_round.sv =====
// ----------------------------------------------------------------------------
// MD5 round unit
// One compression step: the round function, add chain and rotate.
// ----------------------------------------------------------------------------
module md5_round (
  input  logic [5:0]  k,
  input  logic [31:0] a,
  input  logic [31:0] b,
  input  logic [31:0] c,
  input  logic [31:0] d,
  input  logic [31:0] w,
  output logic [31:0] b_new
);
  import md5_pkg::*;

  logic [31:0] f;
  logic [31:0] t;
  logic [4:0]  n;

  // select the round function
  always_comb begin
    case (k[5:4])
      2'd0: f = (b & c) | (~b & d);
      2'd1: f = (b & d) | (c & ~d);
      2'd2: f = b ^ c ^ d;
      default: f = c ^ (b | ~d);
    endcase
  end

  // add, rotate, add
  always_comb begin
    t = a + f + w + step_const(k);
    n = step_rot({k[5:4], k[1:0]});
    b_new = b + ((t << n) | (t >> (6'd32 - {1'b0, n})));
  end

endmodule
